// ----- rtl/core/byte_ring_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Sizes, command codes, shared types and the position rules of the buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned BUF_SIZE = 256;
  localparam int unsigned ADDR_W   = $clog2(BUF_SIZE);
  localparam int unsigned PTR_W    = $clog2(BUF_SIZE + 1);
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CMD_W    = 3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam ptr_t SIZE_P = PTR_W'(BUF_SIZE);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_ADV_RD = 3'd2,
    CMD_ADV_WR = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic  we;
    addr_t wr_addr;
    data_t wr_data;
    logic  re;
    addr_t rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic rd_take;
    logic accepted;
    cnt_t moved;
    cnt_t read_run;
    cnt_t write_run;
    logic is_empty;
    logic is_full;
  } rsp_t;

  typedef struct packed {
    ptr_t rd_pos;
    ptr_t wr_pos;
  } pos_t;

  function automatic logic empty_f(input ptr_t rp, input ptr_t wp);
    return (rp == wp) || ((rp >= SIZE_P) && (wp == '0));
  endfunction

  function automatic logic full_f(input ptr_t rp, input ptr_t wp);
    return ((rp == '0) && (wp >= SIZE_P)) || (PTR_W'(wp + ptr_t'(1)) == rp);
  endfunction

  function automatic ptr_t rd_run_f(input ptr_t rp, input ptr_t wp);
    return (rp > wp) ? ptr_t'(SIZE_P - rp) : ptr_t'(wp - rp);
  endfunction

  function automatic ptr_t wr_run_f(input ptr_t rp, input ptr_t wp);
    return (rp > wp) ? ptr_t'(rp - wp - ptr_t'(1)) : ptr_t'(SIZE_P - wp);
  endfunction

endpackage

// ----- rtl/core/byte_ring_buffer.sv -----
// The result item appears with out_valid in the cycle after start is taken.
// Throughput: one item per cycle while busy is low, with a registered read port in the byte memory.
// Reset is synchronous: both positions clear to zero and the stored bytes are kept.
// busy is high during reset and for the first cycle after it is released.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Byte ring buffer
// Byte FIFO with byte read and write, position advances and a run query.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_macros.svh"

module byte_ring_buffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_write_byte,
  input  logic [8:0] in_count,
  output logic       out_valid,
  output logic [7:0] out_read_byte,
  output logic       out_accepted,
  output logic [8:0] out_moved,
  output logic [8:0] out_read_run,
  output logic [8:0] out_write_run,
  output logic       out_is_empty,
  output logic       out_is_full
);

  logic              in_fire;
  logic              pos_in_range;
  brb_pkg::mem_req_t mem_req;
  brb_pkg::rsp_t     rsp;
  brb_pkg::pos_t     pos;
  brb_pkg::data_t    rd_data;

  assign in_fire = start && !busy;

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .cmd        (in_cmd),
    .write_byte (in_write_byte),
    .count      (in_count),
    .busy       (busy),
    .mem_req    (mem_req),
    .rsp        (rsp),
    .pos        (pos)
  );

  brb_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign out_valid     = rsp.valid;
  assign out_read_byte = rsp.rd_take ? rd_data : '0;
  assign out_accepted  = rsp.accepted;
  assign out_moved     = rsp.moved;
  assign out_read_run  = rsp.read_run;
  assign out_write_run = rsp.write_run;
  assign out_is_empty  = rsp.is_empty;
  assign out_is_full   = rsp.is_full;

  assign pos_in_range = (pos.rd_pos <= brb_pkg::SIZE_P) && (pos.wr_pos <= brb_pkg::SIZE_P);

  `BRB_ASSERT_NEXT(a_item_strobe, in_fire, out_valid, "Accepted item gave no result strobe.")
  `BRB_ASSERT_NEXT(a_no_spurious, !in_fire, !out_valid, "Result strobe without an item.")
  `BRB_ASSERT_SAME(a_flags_excl, out_valid, !(out_is_empty && out_is_full), "Both flags set.")
  `BRB_ASSERT_SAME(a_pos_range, 1'b1, pos_in_range, "Position beyond the buffer end.")

endmodule

// ----- rtl/core/brb_mem.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer storage
// Single-port-write, single-port-read byte memory with a registered read.
// ----------------------------------------------------------------------------
module brb_mem (
  input  logic              clk,
  input  brb_pkg::mem_req_t req,
  output brb_pkg::data_t    rd_data
);

  brb_pkg::data_t mem [brb_pkg::BUF_SIZE];
  brb_pkg::data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Byte ring buffer position control
// Holds the read and write positions, applies the wrap and clamp rules for
// each command, issues the memory access and registers the result item.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [2:0]        cmd,
  input  brb_pkg::data_t    write_byte,
  input  brb_pkg::cnt_t     count,
  output logic              busy,
  output brb_pkg::mem_req_t mem_req,
  output brb_pkg::rsp_t     rsp,
  output brb_pkg::pos_t     pos
);

  brb_pkg::ptr_t rp_r, rp_nxt;
  brb_pkg::ptr_t wp_r, wp_nxt;
  brb_pkg::rsp_t rsp_r, rsp_nxt;
  logic          busy_r;

  always_comb begin
    logic          rd_ok;
    logic          wr_ok;
    brb_pkg::ptr_t rp1;
    brb_pkg::ptr_t wp1;
    brb_pkg::ptr_t avail;
    brb_pkg::ptr_t step;
    brb_pkg::ptr_t cnt_ext;

    rp_nxt  = rp_r;
    wp_nxt  = wp_r;
    rsp_nxt = '0;
    mem_req = '0;
    rd_ok   = 1'b0;
    wr_ok   = 1'b0;
    rp1     = rp_r;
    wp1     = wp_r;
    avail   = '0;
    step    = '0;
    cnt_ext = brb_pkg::PTR_W'(count);

    mem_req.wr_data = write_byte;

    if (fire) begin
      unique case (brb_pkg::cmd_t'(cmd))
        brb_pkg::CMD_WRITE: begin
          wr_ok = !brb_pkg::full_f(rp_r, wp_r);
          if (wr_ok && (wp_r >= brb_pkg::SIZE_P)) begin
            wp1 = '0;
          end
          wp_nxt = wp1;
          avail  = brb_pkg::wr_run_f(rp_r, wp1);
          if (wr_ok && (avail != '0) && (wp1 < brb_pkg::SIZE_P)) begin
            mem_req.we       = 1'b1;
            mem_req.wr_addr  = brb_pkg::ADDR_W'(wp1);
            wp_nxt           = brb_pkg::PTR_W'(wp1 + brb_pkg::ptr_t'(1));
            rsp_nxt.accepted = 1'b1;
          end
        end
        brb_pkg::CMD_READ: begin
          rd_ok = !brb_pkg::empty_f(rp_r, wp_r);
          if (rd_ok && (rp_r >= brb_pkg::SIZE_P)) begin
            rp1 = '0;
          end
          rp_nxt = rp1;
          avail  = brb_pkg::rd_run_f(rp1, wp_r);
          if (rd_ok && (avail != '0) && (rp1 < brb_pkg::SIZE_P)) begin
            mem_req.re       = 1'b1;
            mem_req.rd_addr  = brb_pkg::ADDR_W'(rp1);
            rp_nxt           = brb_pkg::PTR_W'(rp1 + brb_pkg::ptr_t'(1));
            rsp_nxt.accepted = 1'b1;
            rsp_nxt.rd_take  = 1'b1;
          end
        end
        brb_pkg::CMD_ADV_RD: begin
          rd_ok = !brb_pkg::empty_f(rp_r, wp_r);
          if (rd_ok) begin
            if (rp_r >= brb_pkg::SIZE_P) begin
              rp1 = '0;
            end
            avail         = brb_pkg::rd_run_f(rp1, wp_r);
            step          = (cnt_ext < avail) ? cnt_ext : avail;
            rp_nxt        = brb_pkg::PTR_W'(rp1 + step);
            rsp_nxt.moved = brb_pkg::CNT_W'(step);
          end
        end
        brb_pkg::CMD_ADV_WR: begin
          wr_ok = !brb_pkg::full_f(rp_r, wp_r);
          if (wr_ok) begin
            if (wp_r >= brb_pkg::SIZE_P) begin
              wp1 = '0;
            end
            avail         = brb_pkg::wr_run_f(rp_r, wp1);
            step          = (cnt_ext < avail) ? cnt_ext : avail;
            wp_nxt        = brb_pkg::PTR_W'(wp1 + step);
            rsp_nxt.moved = brb_pkg::CNT_W'(step);
          end
        end
        brb_pkg::CMD_QUERY: begin
          rd_ok = !brb_pkg::empty_f(rp_r, wp_r);
          if (rd_ok) begin
            if (rp_r >= brb_pkg::SIZE_P) begin
              rp1 = '0;
            end
            rsp_nxt.read_run = brb_pkg::CNT_W'(brb_pkg::rd_run_f(rp1, wp_r));
          end
          wr_ok = !brb_pkg::full_f(rp1, wp_r);
          if (wr_ok) begin
            if (wp_r >= brb_pkg::SIZE_P) begin
              wp1 = '0;
            end
            rsp_nxt.write_run = brb_pkg::CNT_W'(brb_pkg::wr_run_f(rp1, wp1));
          end
          rp_nxt = rp1;
          wp_nxt = wp1;
        end
        default: begin
          rp_nxt = rp_r;
          wp_nxt = wp_r;
        end
      endcase
    end

    rsp_nxt.valid    = fire;
    rsp_nxt.is_empty = brb_pkg::empty_f(rp_nxt, wp_nxt);
    rsp_nxt.is_full  = brb_pkg::full_f(rp_nxt, wp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      wp_r   <= '0;
      busy_r <= 1'b1;
      rsp_r  <= '0;
    end else begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      busy_r <= 1'b0;
      rsp_r  <= rsp_nxt;
    end
  end

  assign busy       = busy_r;
  assign rsp        = rsp_r;
  assign pos.rd_pos = rp_r;
  assign pos.wr_pos = wp_r;

endmodule

// ----- tb/byte_ring_buffer_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte ring buffer monitor
// Watches the command and result channels of the byte ring buffer. It keeps
// its own copy of the stored bytes and of both positions, works out the
// status that each accepted item must produce, and compares every result
// with the oldest status still owed.
// ----------------------------------------------------------------------------
module byte_ring_buffer_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [brb_pkg::CMD_W-1:0]  in_cmd,
  input  brb_pkg::data_t             in_write_byte,
  input  brb_pkg::cnt_t              in_count,
  input  logic                       out_valid,
  input  brb_pkg::data_t             out_read_byte,
  input  logic                       out_accepted,
  input  brb_pkg::cnt_t              out_moved,
  input  brb_pkg::cnt_t              out_read_run,
  input  brb_pkg::cnt_t              out_write_run,
  input  logic                       out_is_empty,
  input  logic                       out_is_full,
  output int                         fail_count,
  output int                         awaiting,
  output logic                       all_written
);
  import brb_pkg::*;

  typedef struct packed {
    data_t rd_byte;
    logic  accepted;
    cnt_t  moved;
    cnt_t  rd_run;
    cnt_t  wr_run;
    logic  empty;
    logic  full;
  } status_t;

  data_t       store [BUF_SIZE];
  bit          written [BUF_SIZE];
  int unsigned fresh_bytes = BUF_SIZE;
  ptr_t        rd_pos = '0;
  ptr_t        wr_pos = '0;
  status_t     owed_status [$];
  int          errors = 0;

  assign fail_count = errors;

  function automatic bit is_empty_now();
    return (rd_pos == wr_pos) || (rd_pos >= BUF_SIZE && wr_pos == 0);
  endfunction

  function automatic bit is_full_now();
    return (rd_pos == 0 && wr_pos >= BUF_SIZE) || (wr_pos + 1 == rd_pos);
  endfunction

  function automatic bit claim_read_side();
    if (is_empty_now()) return 1'b0;
    if (rd_pos >= BUF_SIZE) rd_pos = '0;
    return 1'b1;
  endfunction

  function automatic bit claim_write_side();
    if (is_full_now()) return 1'b0;
    if (wr_pos >= BUF_SIZE) wr_pos = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned readable_run();
    return (rd_pos > wr_pos) ? BUF_SIZE - rd_pos : wr_pos - rd_pos;
  endfunction

  function automatic int unsigned writable_run();
    return (rd_pos > wr_pos) ? rd_pos - wr_pos - 1 : BUF_SIZE - wr_pos;
  endfunction

  task automatic take_item(input logic [CMD_W-1:0] cmd, input data_t wbyte, input cnt_t cnt,
                           output status_t st);
    int unsigned span;
    st = '0;
    case (cmd)
      CMD_WRITE: begin
        if (claim_write_side() && writable_run() >= 1 && wr_pos < BUF_SIZE) begin
          store[wr_pos[ADDR_W-1:0]] = wbyte;
          if (!written[wr_pos[ADDR_W-1:0]]) begin
            written[wr_pos[ADDR_W-1:0]] = 1'b1;
            fresh_bytes--;
          end
          wr_pos = ptr_t'(wr_pos + 1);
          st.accepted = 1'b1;
        end
      end
      CMD_READ: begin
        if (claim_read_side() && readable_run() >= 1 && rd_pos < BUF_SIZE) begin
          st.rd_byte = store[rd_pos[ADDR_W-1:0]];
          rd_pos = ptr_t'(rd_pos + 1);
          st.accepted = 1'b1;
        end
      end
      CMD_ADV_RD: begin
        if (claim_read_side()) begin
          span = readable_run();
          if (cnt < span) span = 32'(cnt);
          rd_pos = ptr_t'(rd_pos + span);
          st.moved = cnt_t'(span);
        end
      end
      CMD_ADV_WR: begin
        if (claim_write_side()) begin
          span = writable_run();
          if (cnt < span) span = 32'(cnt);
          wr_pos = ptr_t'(wr_pos + span);
          st.moved = cnt_t'(span);
        end
      end
      CMD_QUERY: begin
        if (claim_read_side()) st.rd_run = cnt_t'(readable_run());
        if (claim_write_side()) st.wr_run = cnt_t'(writable_run());
      end
      default: ;
    endcase
    st.empty = is_empty_now();
    st.full  = is_full_now();
  endtask

  task automatic compare_field(input string label, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    status_t fresh;
    status_t want;
    if (!rst_n) begin
      rd_pos = '0;
      wr_pos = '0;
      owed_status.delete();
    end else begin
      if (start && !busy) begin
        take_item(in_cmd, in_write_byte, in_count, fresh);
        owed_status.push_back(fresh);
      end
      if (out_valid) begin
        if (owed_status.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, actual one", $time);
          errors++;
        end else begin
          want = owed_status.pop_front();
          compare_field("read_byte", CNT_W'(want.rd_byte), CNT_W'(out_read_byte));
          compare_field("accepted", CNT_W'(want.accepted), CNT_W'(out_accepted));
          compare_field("moved", want.moved, out_moved);
          compare_field("read_run", want.rd_run, out_read_run);
          compare_field("write_run", want.wr_run, out_write_run);
          compare_field("is_empty", CNT_W'(want.empty), CNT_W'(out_is_empty));
          compare_field("is_full", CNT_W'(want.full), CNT_W'(out_is_full));
        end
      end
    end
    awaiting    <= owed_status.size();
    all_written <= (fresh_bytes == 0);
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte ring buffer testbench
// Sends a short directed sequence, a fill of the whole store and then random
// commands in phases with and without sender gaps. The monitor predicts and
// checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import brb_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 272;
  localparam logic [CMD_W-1:0] CMD_CODE_MAX = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [CMD_W-1:0] in_cmd = '0;
  data_t            in_write_byte = '0;
  cnt_t             in_count = '0;
  logic             busy;
  logic             out_valid;
  data_t            out_read_byte;
  logic             out_accepted;
  cnt_t             out_moved;
  cnt_t             out_read_run;
  cnt_t             out_write_run;
  logic             out_is_empty;
  logic             out_is_full;
  int               fail_count;
  int               awaiting;
  logic             all_written;
  int               idle_pct = 0;
  int               quiet_cycles = 0;

  always #5 clk = ~clk;

  byte_ring_buffer u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_write_byte (in_write_byte),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_read_byte (out_read_byte),
    .out_accepted  (out_accepted),
    .out_moved     (out_moved),
    .out_read_run  (out_read_run),
    .out_write_run (out_write_run),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

  byte_ring_buffer_monitor u_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_write_byte (in_write_byte),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_read_byte (out_read_byte),
    .out_accepted  (out_accepted),
    .out_moved     (out_moved),
    .out_read_run  (out_read_run),
    .out_write_run (out_write_run),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .fail_count    (fail_count),
    .awaiting      (awaiting),
    .all_written   (all_written)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** byte_ring_buffer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The write position may only be advanced once every byte has been written,
  // so that no read can reach a byte that was never stored.
  function automatic cnt_t skip_count(input cnt_t want);
    return all_written ? want : '0;
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input data_t wbyte, input cnt_t cnt);
    while ($urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      in_cmd        <= CMD_W'($urandom);
      in_write_byte <= data_t'($urandom);
      in_count      <= cnt_t'($urandom);
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_write_byte <= wbyte;
    in_count      <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_command(input bit lean_write);
    int unsigned      pick;
    int unsigned      band;
    logic [CMD_W-1:0] cmd;
    cnt_t             cnt;
    pick = $urandom_range(99);
    band = $urandom_range(9);
    if (band <= 5) cnt = cnt_t'($urandom_range(8));
    else if (band <= 7) cnt = cnt_t'($urandom_range(BUF_SIZE));
    else if (band == 8) cnt = cnt_t'(BUF_SIZE);
    else cnt = '0;
    if (pick < (lean_write ? 45 : 25)) begin
      cmd = CMD_WRITE;
    end else if (pick < 62) begin
      cmd = CMD_READ;
    end else if (pick < 72) begin
      cmd = CMD_ADV_RD;
    end else if (pick < 82) begin
      cmd = CMD_ADV_WR;
      cnt = skip_count(cnt);
    end else if (pick < 95) begin
      cmd = CMD_QUERY;
    end else begin
      cmd = CMD_W'($urandom_range(CMD_QUERY + 1, CMD_CODE_MAX));
    end
    issue(cmd, data_t'($urandom), cnt);
  endtask

  initial begin
    int idle_plan [4] = '{0, 88, 18, 0};
    int left;
    int burst;
    bit lean_write;
    lean_write = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(CMD_QUERY, '0, '0);
    issue(CMD_READ, '0, '0);
    issue(CMD_ADV_RD, '0, cnt_t'(BUF_SIZE));
    issue(CMD_ADV_WR, '0, '0);
    for (int c = CMD_QUERY + 1; c <= CMD_CODE_MAX; c++)
      issue(CMD_W'(c), '1, cnt_t'(BUF_SIZE));

    // One write more than the store holds, so the last one meets a full buffer.
    repeat (BUF_SIZE + 1) issue(CMD_WRITE, data_t'($urandom), '0);

    issue(CMD_QUERY, '0, '0);
    issue(CMD_ADV_WR, '0, skip_count(cnt_t'(BUF_SIZE)));
    issue(CMD_ADV_RD, '0, '0);
    issue(CMD_ADV_RD, '0, cnt_t'(BUF_SIZE));
    issue(CMD_QUERY, '0, '0);
    issue(CMD_WRITE, '1, '0);
    issue(CMD_WRITE, '0, '0);
    issue(CMD_READ, '0, '0);
    issue(CMD_READ, '0, '0);
    issue(CMD_READ, '0, '0);
    issue(CMD_ADV_WR, '0, skip_count(cnt_t'(BUF_SIZE)));
    issue(CMD_ADV_RD, '0, cnt_t'(3));
    issue(CMD_QUERY, '0, '0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      left = RANDOM_ITEMS / 4;
      while (left > 0) begin
        burst = $urandom_range(16, 64);
        lean_write = !lean_write;
        while (burst > 0 && left > 0) begin
          random_command(lean_write);
          burst--;
          left--;
        end
      end
    end

    start <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaiting == 0)
      $display("** byte_ring_buffer: PASSED **");
    else
      $display("** byte_ring_buffer: FAILED **");
    $finish;
  end

endmodule
